[src/spi_mbe_pkg.sv]
// shared types, codes and constants for the spi master byte engine
package spi_mbe_pkg;

	// word length and derived widths
	localparam int unsigned BITS_PER_WORD = 8;
	localparam int unsigned BIT_IDX_W     = $clog2(BITS_PER_WORD);

	// command queue between front and back
	localparam int unsigned CMD_DEPTH = 4;
	localparam int unsigned CMD_AW    = $clog2(CMD_DEPTH);

	// result buffer
	localparam int unsigned RES_DEPTH = 2;
	localparam int unsigned RES_AW    = $clog2(RES_DEPTH);

	// configuration port
	localparam int unsigned CFG_AW = 3;
	localparam int unsigned CFG_DW = 32;

	// input action codes
	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_START   = 2'd1,
		ACT_CS_LOW  = 2'd2,
		ACT_CS_HIGH = 2'd3
	} action_t;

	// configuration register indexes
	typedef enum logic {
		REG_CLOCK_MODE  = 1'b0,
		REG_PHASE_TICKS = 1'b1
	} reg_idx_t;

	// one input item
	typedef struct packed {
		logic [1:0] action;
		logic [7:0] tx_byte;
		logic [1:0] tx_mode;
		logic [1:0] rx_mode;
		logic       miso_level;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic       sck_out;
		logic       mosi_out;
		logic       cs_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
	} out_item_t;

	// classified command handed from front to back
	typedef struct packed {
		logic       start;
		logic       cs_set;
		logic       cs_level;
		logic [7:0] tx_byte;
		logic [1:0] tx_mode;
		logic [1:0] rx_mode;
		logic       miso;
	} cmd_t;

	// configuration write towards the back
	typedef struct packed {
		logic       en;
		reg_idx_t   index;
		logic [7:0] data;
	} cfg_wr_t;

endpackage

[src/spi_master_byte_engine_core.sv]
// top level of the spi master byte engine
//
// Each input item is one tick of the pin timing. Items go in through push/full
// and are accepted on a rising edge with push high and full low; one result
// item leaves for every input item through empty/pop, oldest first.
// A start item in the idle phase latches the byte and the transmit and receive
// modes; chip select items drive the select pin directly. Every delay phase
// lasts phase_ticks + 1 ticks.
// An accepted item passes the front register, then the command queue; the
// sequencer tick and the result write share one edge. Throughput is one item
// per cycle while results are popped, since the sequencer updates its state
// once per tick.
// While the receiver stalls, results collect in a two-entry buffer, then
// commands in the four-entry queue and the front register; full rises only
// once all three are taken up.
// Configuration is written over the APB-style port: clock_mode at address 0,
// phase_ticks at address 4; pready is always high and reads are immediate.
// Reset leaves the clock pin low, data low, select high, both registers zero
// and every queue empty.
module spi_master_byte_engine_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  spi_mbe_pkg::in_item_t               item,
	output logic                                empty,
	input  logic                                pop,
	output spi_mbe_pkg::out_item_t              result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [spi_mbe_pkg::CFG_AW-1:0]      paddr,
	input  logic [spi_mbe_pkg::CFG_DW-1:0]      pwdata,
	output logic [spi_mbe_pkg::CFG_DW-1:0]      prdata,
	output logic                                pready
);

	logic                 cmd_push;
	logic                 cmd_full;
	logic                 cmd_pop;
	logic                 cmd_empty;
	spi_mbe_pkg::cmd_t    cmd_in;
	spi_mbe_pkg::cmd_t    cmd_out;
	spi_mbe_pkg::cfg_wr_t cfg_wr;
	logic [1:0]           clock_mode;
	logic [7:0]           phase_ticks;

	// configuration write decode
	assign pready       = 1'b1;
	assign cfg_wr.en    = psel && penable && pwrite && pready;
	assign cfg_wr.index = spi_mbe_pkg::reg_idx_t'(paddr[2]);
	assign cfg_wr.data  = pwdata[7:0];

	// configuration read-back
	always_comb begin
		unique case (spi_mbe_pkg::reg_idx_t'(paddr[2]))
			spi_mbe_pkg::REG_CLOCK_MODE:  prdata = {30'd0, clock_mode};
			spi_mbe_pkg::REG_PHASE_TICKS: prdata = {24'd0, phase_ticks};
			default:                      prdata = '0;
		endcase
	end

	spi_mbe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.cmd_full (cmd_full)
	);

	spi_mbe_cmd_fifo u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty)
	);

	spi_mbe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_out),
		.cmd_empty   (cmd_empty),
		.cmd_pop     (cmd_pop),
		.cfg_wr      (cfg_wr),
		.clock_mode  (clock_mode),
		.phase_ticks (phase_ticks),
		.empty       (empty),
		.pop         (pop),
		.result      (result)
	);

endmodule

[src/spi_mbe_front.sv]
// front stage: accepts input items and classifies them into commands
module spi_mbe_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  spi_mbe_pkg::in_item_t item,
	output logic                  cmd_push,
	output spi_mbe_pkg::cmd_t     cmd,
	input  logic                  cmd_full
);

	logic              valid_s1;
	spi_mbe_pkg::cmd_t cmd_s1;
	spi_mbe_pkg::cmd_t cmd_d;
	logic              advance;

	// decode the action into command flags
	always_comb begin
		cmd_d.start    = (item.action == spi_mbe_pkg::ACT_START);
		cmd_d.cs_set   = (item.action == spi_mbe_pkg::ACT_CS_LOW)
			|| (item.action == spi_mbe_pkg::ACT_CS_HIGH);
		cmd_d.cs_level = (item.action == spi_mbe_pkg::ACT_CS_HIGH);
		cmd_d.tx_byte  = item.tx_byte;
		cmd_d.tx_mode  = item.tx_mode;
		cmd_d.rx_mode  = item.rx_mode;
		cmd_d.miso     = item.miso_level;
	end

	// stage moves when empty or when the queue takes its command
	assign advance  = !valid_s1 || !cmd_full;
	assign full     = !advance;
	assign cmd_push = valid_s1 && !cmd_full;
	assign cmd      = cmd_s1;

	// stage valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (advance && push) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

[src/spi_mbe_cmd_fifo.sv]
// short command queue between front and back
module spi_mbe_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  spi_mbe_pkg::cmd_t din,
	output logic              full,
	input  logic              pop,
	output spi_mbe_pkg::cmd_t dout,
	output logic              empty
);

	spi_mbe_pkg::cmd_t                 mem_q [spi_mbe_pkg::CMD_DEPTH];
	logic [spi_mbe_pkg::CMD_AW-1:0]    wr_ptr_q;
	logic [spi_mbe_pkg::CMD_AW-1:0]    rd_ptr_q;
	logic [spi_mbe_pkg::CMD_AW:0]      count_q;
	logic                              do_push;
	logic                              do_pop;

	assign full    = (count_q == (spi_mbe_pkg::CMD_AW+1)'(spi_mbe_pkg::CMD_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (!do_push && do_pop) count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

[src/spi_mbe_back.sv]
// back end: pin timing sequencer, configuration registers and result buffer
module spi_mbe_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  spi_mbe_pkg::cmd_t      cmd,
	input  logic                   cmd_empty,
	output logic                   cmd_pop,
	input  spi_mbe_pkg::cfg_wr_t   cfg_wr,
	output logic [1:0]             clock_mode,
	output logic [7:0]             phase_ticks,
	output logic                   empty,
	input  logic                   pop,
	output spi_mbe_pkg::out_item_t result
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_PRE   = 3'd1,
		PH_SETUP = 3'd2,
		PH_LEAD  = 3'd3,
		PH_MID   = 3'd4,
		PH_TRAIL = 3'd5,
		PH_POST  = 3'd6
	} phase_t;

	localparam logic [spi_mbe_pkg::BIT_IDX_W-1:0] TOP_BIT =
		spi_mbe_pkg::BIT_IDX_W'(spi_mbe_pkg::BITS_PER_WORD - 1);

	phase_t                                phase_q, phase_d;
	logic [spi_mbe_pkg::BIT_IDX_W-1:0]     bit_q, bit_d;
	logic [7:0]                            wait_q, wait_d;
	logic [spi_mbe_pkg::BITS_PER_WORD-1:0] tx_q, tx_d;
	logic [spi_mbe_pkg::BITS_PER_WORD-1:0] rx_q, rx_d;
	logic [1:0]                            txm_q, txm_d;
	logic                                  lead_q, lead_d;
	logic                                  sck_q, sck_d;
	logic                                  mosi_q, mosi_d;
	logic                                  cs_q, cs_d;
	logic                                  done_d;
	logic [1:0]                            clock_mode_q;
	logic [7:0]                            phase_ticks_q;

	spi_mbe_pkg::out_item_t                res_mem_q [spi_mbe_pkg::RES_DEPTH];
	logic [spi_mbe_pkg::RES_AW-1:0]        res_wr_q;
	logic [spi_mbe_pkg::RES_AW-1:0]        res_rd_q;
	logic [spi_mbe_pkg::RES_AW:0]          res_cnt_q;
	logic                                  res_room;
	logic                                  res_pop;
	logic                                  take;
	spi_mbe_pkg::out_item_t                res_d;

	// take a command whenever the result buffer has a free slot
	assign res_room = (res_cnt_q != (spi_mbe_pkg::RES_AW+1)'(spi_mbe_pkg::RES_DEPTH));
	assign take     = !cmd_empty && res_room;
	assign cmd_pop  = take;
	assign res_pop  = pop && !empty;
	assign empty    = (res_cnt_q == '0);
	assign result   = res_mem_q[res_rd_q];

	assign clock_mode  = clock_mode_q;
	assign phase_ticks = phase_ticks_q;

	// next state for one tick
	always_comb begin
		phase_d = phase_q;
		bit_d   = bit_q;
		wait_d  = wait_q;
		tx_d    = tx_q;
		rx_d    = rx_q;
		txm_d   = txm_q;
		lead_d  = lead_q;
		sck_d   = sck_q;
		mosi_d  = mosi_q;
		cs_d    = cs_q;
		done_d  = 1'b0;

		// select pin follows commands at once
		if (cmd.cs_set) cs_d = cmd.cs_level;

		if (phase_q == PH_IDLE) begin
			// latch a new transfer
			if (cmd.start) begin
				tx_d    = cmd.tx_byte;
				rx_d    = '0;
				txm_d   = cmd.tx_mode;
				lead_d  = ((cmd.tx_mode[1] == cmd.rx_mode[1]) == (cmd.rx_mode[0] == 1'b0));
				bit_d   = TOP_BIT;
				sck_d   = cmd.tx_mode[1];
				phase_d = PH_PRE;
				wait_d  = phase_ticks_q;
			end
		end else if (wait_q != '0) begin
			// delay count-down
			wait_d = wait_q - 1'b1;
		end else begin
			unique case (phase_q)
				PH_PRE: begin
					bit_d = TOP_BIT;
					if (!txm_q[0]) mosi_d = tx_q[TOP_BIT];
					phase_d = PH_SETUP;
					wait_d  = phase_ticks_q;
				end
				PH_SETUP: begin
					sck_d   = !txm_q[1];
					phase_d = PH_LEAD;
					wait_d  = phase_ticks_q;
				end
				PH_LEAD: begin
					if (lead_q) rx_d = {rx_q[spi_mbe_pkg::BITS_PER_WORD-2:0], cmd.miso};
					if (txm_q[0]) mosi_d = tx_q[bit_q];
					phase_d = PH_MID;
					wait_d  = phase_ticks_q;
				end
				PH_MID: begin
					sck_d   = txm_q[1];
					phase_d = PH_TRAIL;
					wait_d  = phase_ticks_q;
				end
				PH_TRAIL: begin
					if (!lead_q) rx_d = {rx_q[spi_mbe_pkg::BITS_PER_WORD-2:0], cmd.miso};
					if (bit_q == '0) begin
						phase_d = PH_POST;
					end else begin
						bit_d = bit_q - 1'b1;
						if (!txm_q[0]) mosi_d = tx_q[bit_q - 1'b1];
						phase_d = PH_SETUP;
					end
					wait_d = phase_ticks_q;
				end
				PH_POST: begin
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end

		res_d.sck_out  = sck_d;
		res_d.mosi_out = mosi_d;
		res_d.cs_out   = cs_d;
		res_d.busy_res = (phase_d != PH_IDLE);
		res_d.done_res = done_d;
		res_d.rx_byte  = rx_d;
	end

	// sequencer state, pins and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bit_q         <= TOP_BIT;
			wait_q        <= '0;
			tx_q          <= '0;
			rx_q          <= '0;
			txm_q         <= '0;
			lead_q        <= 1'b0;
			sck_q         <= 1'b0;
			mosi_q        <= 1'b0;
			cs_q          <= 1'b1;
			clock_mode_q  <= '0;
			phase_ticks_q <= '0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				bit_q   <= bit_d;
				wait_q  <= wait_d;
				tx_q    <= tx_d;
				rx_q    <= rx_d;
				txm_q   <= txm_d;
				lead_q  <= lead_d;
				sck_q   <= sck_d;
				mosi_q  <= mosi_d;
				cs_q    <= cs_d;
			end
			if (cfg_wr.en) begin
				unique case (cfg_wr.index)
					spi_mbe_pkg::REG_CLOCK_MODE: begin
						clock_mode_q <= cfg_wr.data[1:0];
						if (phase_q == PH_IDLE) sck_q <= cfg_wr.data[1];
					end
					spi_mbe_pkg::REG_PHASE_TICKS: begin
						phase_ticks_q <= cfg_wr.data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// result buffer pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (take) res_wr_q <= res_wr_q + 1'b1;
			if (res_pop) res_rd_q <= res_rd_q + 1'b1;
			if (take && !res_pop) res_cnt_q <= res_cnt_q + 1'b1;
			else if (!take && res_pop) res_cnt_q <= res_cnt_q - 1'b1;
		end
	end

	// result buffer storage
	always_ff @(posedge clk) begin
		if (take) begin
			res_mem_q[res_wr_q] <= res_d;
		end
	end

endmodule

[src/spi_mbe_checker.sv]
// port-level checks for the spi master byte engine, bound to the top level
module spi_mbe_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   full,
	input logic                   empty,
	input logic                   pop,
	input spi_mbe_pkg::out_item_t result,
	input logic                   pready
);

	// a waiting result holds until it is taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while stalled");

	// completion is reported with the transfer already finished
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.done_res |-> !result.busy_res)
		else $error("done with busy set");

	// a done pulse never repeats on the next result
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && result.done_res ##1 !empty |-> !result.done_res)
		else $error("done repeated");

	// the configuration port never waits
	a_pready_high: assert property (@(posedge clk) pready)
		else $error("pready low");

	// the queue cannot be full straight after reset
	a_full_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !full)
		else $error("full right after reset");

endmodule

bind spi_master_byte_engine_core spi_mbe_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result),
	.pready (pready)
);
